// ----- rtl/hnt_pkg.sv -----
// ----------------------------------------------------------------------------
// hnt_pkg
// Shared constants and types for the heard node table.
// ----------------------------------------------------------------------------
package hnt_pkg;

   localparam int NODES  = 16;
   localparam int IDX_W  = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int CNT_W  = $clog2(NODES + 1);

   localparam int NUM_W  = 32;
   localparam int SIG_W  = 16;
   localparam int HOPS_W = 3;
   localparam int TIME_W = 32;
   localparam int QIDX_W = 4;
   localparam int SLOT_W = 4;
   localparam int VC_W   = 5;

   localparam logic FUNC_HEARD = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic        [NUM_W-1:0]  num;
      logic signed [SIG_W-1:0]  rssi;
      logic signed [SIG_W-1:0]  snr;
      logic        [HOPS_W-1:0] hops;
      logic        [TIME_W-1:0] heard;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

// ----- rtl/hnt_ram.sv -----
// ----------------------------------------------------------------------------
// hnt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hnt_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/heard_node_table_lru_core.sv -----
// ----------------------------------------------------------------------------
// heard_node_table_lru_core
// Table of heard nodes: refresh on hit, fill first free slot, else evict the
// entry with the greatest signed age. Query returns the n-th valid entry.
// ----------------------------------------------------------------------------
// Each request scans the entry RAM one slot per cycle through its single read
//    port; no new request is taken until the scan and its finish are done.
// The next request is taken while the previous response waits on rsp_ready.
// Reset clears the valid bits, the count and rsp_valid; the entry RAM is not
//    cleared and its contents are only used where the valid bit is set.
// ----------------------------------------------------------------------------
module heard_node_table_lru_core
   import hnt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_func,
   input  logic        [NUM_W-1:0]  req_node_num,
   input  logic signed [SIG_W-1:0]  req_rssi,
   input  logic signed [SIG_W-1:0]  req_snr,
   input  logic        [HOPS_W-1:0] req_hops,
   input  logic        [TIME_W-1:0] req_now_ms,
   input  logic        [QIDX_W-1:0] req_query_index,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic        [SLOT_W-1:0] rsp_slot,
   output logic                     rsp_is_new,
   output logic                     rsp_evicted,
   output logic        [NUM_W-1:0]  rsp_evicted_num,
   output logic        [VC_W-1:0]   rsp_valid_count,
   output logic                     rsp_found,
   output logic        [NUM_W-1:0]  rsp_node_num_out,
   output logic signed [SIG_W-1:0]  rsp_rssi_out,
   output logic signed [SIG_W-1:0]  rsp_snr_out,
   output logic        [HOPS_W-1:0] rsp_hops_out,
   output logic        [TIME_W-1:0] rsp_heard_ms_out
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   rd_cnt_ff, rd_cnt_in;
   logic               chk_ff, chk_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_slot_ff, hit_slot_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   free_slot_ff, free_slot_in;
   logic [TIME_W-1:0]  best_age_ff, best_age_in;
   logic [IDX_W-1:0]   best_slot_ff, best_slot_in;
   logic [NUM_W-1:0]   best_num_ff, best_num_in;
   logic [CNT_W-1:0]   seen_ff, seen_in;
   logic               found_ff, found_in;
   entry_type          fnd_entry_ff, fnd_entry_in;
   logic [NODES-1:0]   valid_ff, valid_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic               func_ff;
   entry_type          req_entry_ff;
   logic [QIDX_W-1:0]  qidx_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic               rsp_is_new_ff, rsp_is_new_in;
   logic               rsp_evicted_ff, rsp_evicted_in;
   logic [NUM_W-1:0]   rsp_ev_num_ff, rsp_ev_num_in;
   logic [VC_W-1:0]    rsp_vc_ff, rsp_vc_in;
   logic               rsp_found_ff, rsp_found_in;
   entry_type          rsp_entry_ff, rsp_entry_in;

   logic               accept;
   logic               finish_go;
   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [IDX_W-1:0]   ram_raddr;
   entry_type          rd_entry;
   logic [ENTRY_W-1:0] rd_raw;
   logic [TIME_W-1:0]  age;
   logic               cur_valid;
   logic [IDX_W-1:0]   sel_slot;

   hnt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NODES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_entry_ff),
      .rd_addr (ram_raddr),
      .rd_data (rd_raw)
   );

   assign rd_entry  = entry_type'(rd_raw);
   assign age       = req_entry_ff.heard - rd_entry.heard;
   assign cur_valid = valid_ff[chk_idx_ff];
   assign ram_raddr = rd_cnt_ff[IDX_W-1:0];
   assign ram_waddr = sel_slot;
   assign sel_slot  = hit_ff ? hit_slot_ff : (free_ff ? free_slot_ff : best_slot_ff);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign finish_go = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_cnt_ff      <= rd_cnt_in;
      chk_ff         <= chk_in;
      chk_idx_ff     <= chk_idx_in;
      hit_ff         <= hit_in;
      hit_slot_ff    <= hit_slot_in;
      free_ff        <= free_in;
      free_slot_ff   <= free_slot_in;
      best_age_ff    <= best_age_in;
      best_slot_ff   <= best_slot_in;
      best_num_ff    <= best_num_in;
      seen_ff        <= seen_in;
      found_ff       <= found_in;
      fnd_entry_ff   <= fnd_entry_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_is_new_ff  <= rsp_is_new_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_ev_num_ff  <= rsp_ev_num_in;
      rsp_vc_ff      <= rsp_vc_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_entry_ff   <= rsp_entry_in;
      if (accept) begin
         func_ff            <= req_func;
         req_entry_ff.num   <= req_node_num;
         req_entry_ff.rssi  <= req_rssi;
         req_entry_ff.snr   <= req_snr;
         req_entry_ff.hops  <= req_hops;
         req_entry_ff.heard <= req_now_ms;
         qidx_ff            <= req_query_index;
      end
   end

   always_comb begin
      state_in       = state_ff;
      rd_cnt_in      = rd_cnt_ff;
      chk_in         = chk_ff;
      chk_idx_in     = chk_idx_ff;
      hit_in         = hit_ff;
      hit_slot_in    = hit_slot_ff;
      free_in        = free_ff;
      free_slot_in   = free_slot_ff;
      best_age_in    = best_age_ff;
      best_slot_in   = best_slot_ff;
      best_num_in    = best_num_ff;
      seen_in        = seen_ff;
      found_in       = found_ff;
      fnd_entry_in   = fnd_entry_ff;
      valid_in       = valid_ff;
      count_in       = count_ff;
      ram_we         = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_slot_in    = rsp_slot_ff;
      rsp_is_new_in  = rsp_is_new_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_ev_num_in  = rsp_ev_num_ff;
      rsp_vc_in      = rsp_vc_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_entry_in   = rsp_entry_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in  = ST_SCAN;
               rd_cnt_in = '0;
               chk_in    = 1'b0;
               hit_in    = 1'b0;
               free_in   = 1'b0;
               found_in  = 1'b0;
               seen_in   = '0;
            end
         end
         ST_SCAN: begin
            chk_in     = (rd_cnt_ff < CNT_W'(NODES));
            chk_idx_in = ram_raddr;
            if (rd_cnt_ff < CNT_W'(NODES)) begin
               rd_cnt_in = rd_cnt_ff + CNT_W'(1);
            end
            if (chk_ff) begin
               if (cur_valid && (rd_entry.num == req_entry_ff.num) && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_slot_in = chk_idx_ff;
               end
               if (!cur_valid && !free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = chk_idx_ff;
               end
               if ((chk_idx_ff == '0) || ($signed(age) > $signed(best_age_ff))) begin
                  best_age_in  = age;
                  best_slot_in = chk_idx_ff;
                  best_num_in  = rd_entry.num;
               end
               if (cur_valid && !found_ff) begin
                  if (seen_ff == CNT_W'(qidx_ff)) begin
                     found_in     = 1'b1;
                     fnd_entry_in = rd_entry;
                  end
                  seen_in = seen_ff + CNT_W'(1);
               end
            end
            if (rd_cnt_ff == CNT_W'(NODES)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_go) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_slot_in    = '0;
               rsp_is_new_in  = 1'b0;
               rsp_evicted_in = 1'b0;
               rsp_ev_num_in  = '0;
               rsp_found_in   = 1'b0;
               rsp_entry_in   = '0;
               if (func_ff == FUNC_HEARD) begin
                  ram_we             = 1'b1;
                  valid_in[sel_slot] = 1'b1;
                  rsp_slot_in        = SLOT_W'(sel_slot);
                  rsp_is_new_in      = !hit_ff;
                  if (!hit_ff && free_ff) begin
                     count_in = count_ff + CNT_W'(1);
                  end
                  if (!hit_ff && !free_ff) begin
                     rsp_evicted_in = 1'b1;
                     rsp_ev_num_in  = best_num_ff;
                  end
               end else if (found_ff) begin
                  rsp_found_in = 1'b1;
                  rsp_entry_in = fnd_entry_ff;
               end
               rsp_vc_in = VC_W'(count_in);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_is_new       = rsp_is_new_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_num  = rsp_ev_num_ff;
   assign rsp_valid_count  = rsp_vc_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_node_num_out = rsp_entry_ff.num;
   assign rsp_rssi_out     = rsp_entry_ff.rssi;
   assign rsp_snr_out      = rsp_entry_ff.snr;
   assign rsp_hops_out     = rsp_entry_ff.hops;
   assign rsp_heard_ms_out = rsp_entry_ff.heard;

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(count_ff))
      else $error("valid count out of step with valid bits");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(NODES))
      else $error("valid count above table size");

   a_hit_slot_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && func_ff == FUNC_HEARD && hit_ff) |-> valid_ff[hit_slot_ff])
      else $error("hit on an invalid slot");

   a_evict_only_full: assert property (@(posedge clock) disable iff (reset)
      (finish_go && func_ff == FUNC_HEARD && !hit_ff && !free_ff) |-> (&valid_ff))
      else $error("eviction while a free slot exists");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish");

endmodule
